/* rtl/mapss_pkg.sv */
`timescale 1ns / 1ps
package mapss_pkg;
    localparam int MaxB      = 1024;
    localparam int ValueBits = 32;
    localparam int SumBits   = ValueBits + 1;
    localparam int BAddrW    = $clog2(MaxB);
    localparam int BCntW     = BAddrW + 1;
    localparam int ACntW     = 16;

    typedef struct packed {
        logic load_b;
        logic start_a;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic b_full;
    } t_sts;
endpackage

/* rtl/mapss_ram.sv */
`timescale 1ns / 1ps
module mapss_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/mapss_dp.sv */
`timescale 1ns / 1ps
module mapss_dp import mapss_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [ValueBits-1:0] i_value,
    output t_sts                 o_sts,
    output logic [ACntW-1:0]     o_a_index,
    output logic [BCntW-1:0]     o_b_index,
    output logic [SumBits-1:0]   o_min_abs_sum,
    output logic                 o_found
);
    // linear scan over the stored b set, one entry per cycle, pipelined read
    logic [BCntW-1:0]     r_b_count;
    logic [ACntW-1:0]     r_a_count;
    logic [SumBits-1:0]   r_best_sum;
    logic [ACntW-1:0]     r_best_a;
    logic [BCntW-1:0]     r_best_b;
    logic [ValueBits-1:0] r_a_val;
    logic [BCntW-1:0]     r_rd_idx;
    logic                 r_rd_vld;
    logic [BCntW-1:0]     r_cmp_idx;
    logic [SumBits-1:0]   r_cand;
    logic [BCntW-1:0]     r_cand_b;
    logic                 r_cand_vld;
    logic                 r_query;
    logic [ValueBits-1:0] w_rdata;
    logic signed [SumBits-1:0] w_sum;
    logic [SumBits-1:0]   w_abs;
    logic                 w_issue;
    logic                 w_load;

    mapss_ram #(.Width(ValueBits), .Depth(MaxB)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (r_b_count[BAddrW-1:0]),
        .i_wdata (i_value),
        .i_raddr (r_rd_idx[BAddrW-1:0]),
        .o_rdata (w_rdata)
    );

    // the b set is frozen once the first a of a job arrives
    assign w_load = i_cmd.load_b && !o_sts.b_full && !r_query;
    assign o_sts.b_full = (r_b_count == BCntW'(MaxB));
    assign w_issue = i_cmd.step && (r_rd_idx < r_b_count);
    assign o_sts.scan_done = i_cmd.step && !w_issue && !r_rd_vld;
    assign w_sum = SumBits'($signed(r_a_val)) + SumBits'($signed(w_rdata));
    assign w_abs = w_sum[SumBits-1] ? SumBits'(-w_sum) : SumBits'(w_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_b_count  <= '0;
            r_a_count  <= '0;
            r_best_sum <= '1;
            r_best_a   <= '0;
            r_best_b   <= '0;
            r_rd_vld   <= 1'b0;
            r_cand_vld <= 1'b0;
            r_rd_idx   <= '0;
            r_query    <= 1'b0;
        end else begin
            if (w_load) begin
                r_b_count <= r_b_count + 1'b1;
            end
            if (i_cmd.start_a) begin
                r_query    <= 1'b1;
                r_a_val    <= i_value;
                r_rd_idx   <= '0;
                r_cand_vld <= 1'b0;
                r_rd_vld   <= 1'b0;
                if (r_a_count != '1) begin
                    r_a_count <= r_a_count + 1'b1;
                end
            end else if (i_cmd.step) begin
                r_rd_vld  <= w_issue;
                r_cmp_idx <= r_rd_idx;
                if (w_issue) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
                if (r_rd_vld && (!r_cand_vld || w_abs < r_cand)) begin
                    r_cand     <= w_abs;
                    r_cand_b   <= r_cmp_idx + 1'b1;
                    r_cand_vld <= 1'b1;
                end
                if (o_sts.scan_done && r_cand_vld && r_cand < r_best_sum) begin
                    r_best_sum <= r_cand;
                    r_best_a   <= r_a_count;
                    r_best_b   <= r_cand_b;
                end
            end
        end
    end

    // final values merge the candidate of the last a combinationally
    logic w_take;
    assign w_take = r_cand_vld && r_cand < r_best_sum;
    assign o_found       = (r_b_count != '0);
    assign o_a_index     = !o_found ? '0 : (w_take ? r_a_count : r_best_a);
    assign o_b_index     = !o_found ? '0 : (w_take ? r_cand_b : r_best_b);
    assign o_min_abs_sum = !o_found ? '0 : (w_take ? r_cand : r_best_sum);
endmodule

/* rtl/mapss_ctrl.sv */
`timescale 1ns / 1ps
module mapss_ctrl import mapss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_op,
    input  logic i_last,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_out_load,
    input  logic i_out_free
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;
    t_state r_state, n_state;
    logic r_last, n_last;

    always_comb begin
        n_state    = r_state;
        n_last     = r_last;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!i_op) begin
                        o_cmd.load_b = 1'b1;
                    end else begin
                        o_cmd.start_a = 1'b1;
                        n_last  = i_last;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = r_last ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_out_load   = 1'b1;
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    // b loads are only taken while idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_b |-> r_state == S_IDLE)
        else $error("b load outside idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_load |=> r_state == S_IDLE)
        else $error("result not followed by idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_b, o_cmd.start_a, o_cmd.step, o_cmd.finish}))
        else $error("conflicting commands");
endmodule

/* rtl/min_abs_pair_sum_search.sv */
`timescale 1ns / 1ps
// an a item scans the stored b set through the single read port of the
// b store, one entry per cycle; no new item is taken until that scan ends
// b items are taken one per cycle while the controller is idle
// after the last a scan ends, the result is loaded into the output register once it is free
// reset: synchronous active-low, clears counts and best values; b store not cleared
module min_abs_pair_sum_search import mapss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // value[31:0]
    input  logic        s_axis_tuser,  // op
    input  logic        s_axis_tlast,  // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // a_index[15:0], b_index[26:16],
                                       // min_abs_sum[59:27], found[60]
);
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_out_load;
    logic [ACntW-1:0]   w_a_index;
    logic [BCntW-1:0]   w_b_index;
    logic [SumBits-1:0] w_sum;
    logic               w_found;
    logic               r_out_vld;
    logic [63:0]        r_out_data;

    mapss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (s_axis_tuser),
        .i_last     (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_out_load (w_out_load),
        .i_out_free (!r_out_vld || m_axis_tready)
    );

    mapss_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_value       (s_axis_tdata[ValueBits-1:0]),
        .o_sts         (w_sts),
        .o_a_index     (w_a_index),
        .o_b_index     (w_b_index),
        .o_min_abs_sum (w_sum),
        .o_found       (w_found)
    );

    // output register: result waits here while a new job loads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
        if (w_out_load) begin
            r_out_data <= {3'b000, w_found, w_sum, w_b_index, w_a_index};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> m_axis_tvalid)
        else $error("result lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> !m_axis_tvalid || m_axis_tready)
        else $error("result overwritten");
endmodule
